>>> hw/rtl/clut_texture_decode_bgr555_macros.svh
// Assertion macros shared by the checkers of the CLUT texture decoder.
// No dependencies; included by clutd_checker.sv.
`ifndef CLUT_TEXTURE_DECODE_BGR555_MACROS_SVH
`define CLUT_TEXTURE_DECODE_BGR555_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLUTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLUTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/clutd_pkg.sv
// Shared types, codes and helpers of the CLUT texture decoder.
// No dependencies; used by the top level.
package clutd_pkg;

    // request kinds
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // configuration register indexes
    localparam logic REG_PIXEL_MODE    = 1'b0;
    localparam logic REG_PALETTE_COUNT = 1'b1;

    // pixel modes; mode 3 behaves as direct color
    localparam logic [1:0] MODE_4BIT  = 2'd0;
    localparam logic [1:0] MODE_8BIT  = 2'd1;
    localparam logic [1:0] MODE_16BIT = 2'd2;

    localparam logic [3:0] NIBBLE_MASK  = 4'hF;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // where a pixel's color word comes from
    typedef enum logic [1:0] {
        SRC_TABLE  = 2'd0,
        SRC_ZERO   = 2'd1,
        SRC_DIRECT = 2'd2
    } src_t;

    // control carried alongside a table read
    typedef struct packed {
        src_t        src;
        logic [15:0] direct;
        logic        last;
    } pix_ctl_t;

    // 5-bit channel to 8 bits by top-bit replication
    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

>>> hw/rtl/clutd_palette_ram.sv
// Color table storage: one write port, one registered read port.
// Depends on nothing; instantiated by clut_texture_decode_bgr555.
module clutd_palette_ram #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [15:0]      wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [15:0]      rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // read-before-write on a shared address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/clut_texture_decode_bgr555.sv
// Top level of the CLUT texture decoder: BGR555 halfwords to RGBA pixels.
// Depends on clutd_pkg and clutd_palette_ram.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   in       | in  | in_valid / in_ready  | cmd palette_index palette_color
//            |     |                      | texture_word final_word
//   out      | out | out_valid/out_ready  | red green blue alpha last_pixel
//   cfg      | in  | cfg_we (no wait)     | cfg_addr cfg_wdata
//
// Pixels: a decode request yields 4 pixels in 4-bit mode, 2 in 8-bit mode and
//   1 in direct mode; a table write yields none. The single read port of the
//   color table gives one read, hence one pixel, per cycle unless stalled.
// Path: sequencer, then read stage (table read), then output register.
// Reset: control and config clear at once; no clearing pass, the table is
//   undefined until written.
// Stalls: the output register frees the pipe, so a new request is taken in
//   the same cycle as the last table read of the previous one.
module clut_texture_decode_bgr555 #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  palette_index,
    input  logic [15:0] palette_color,
    input  logic [15:0] texture_word,
    input  logic        final_word,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_pixel
);

    localparam int         IDX_W     = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    // configuration
    logic [1:0] mode_reg;
    logic [8:0] count_reg;

    // sequencer: the halfword being split into pixels
    logic        seq_valid_reg;
    logic [1:0]  seq_cnt_reg;     // pixels left after the current one
    logic [15:0] seq_word_reg;
    logic [1:0]  seq_mode_reg;
    logic        seq_fin_reg;

    // read stage: table read in flight
    logic                rd_valid_reg;
    clutd_pkg::pix_ctl_t rd_ctl_reg;
    clutd_pkg::pix_ctl_t rd_ctl_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic       last_reg;

    logic             out_free;
    logic             rd_move;
    logic             rd_free;
    logic             issue;
    logic             seq_done;
    logic             in_take;
    logic             dec_take;
    logic             wr_take;
    logic             ram_we;
    logic [7:0]       seq_idx;
    logic             in_table;
    logic [IDX_W-1:0] ram_raddr;
    logic [15:0]      ram_rdata;
    logic [15:0]      color;
    logic [1:0]       cnt_load;

    // -------- pipeline flow --------
    assign out_free = !out_valid_reg || out_ready;
    assign rd_move  = rd_valid_reg && out_free;
    assign rd_free  = !rd_valid_reg || rd_move;
    assign issue    = seq_valid_reg && rd_free;
    assign seq_done = issue && (seq_cnt_reg == 2'd0);

    // a write may pass only once every pixel of an earlier decode has read
    assign in_ready = !seq_valid_reg || seq_done;
    assign in_take  = in_valid && in_ready;
    assign dec_take = in_take && (cmd == clutd_pkg::CMD_DECODE);
    assign wr_take  = in_take && (cmd == clutd_pkg::CMD_WRITE);
    assign ram_we   = wr_take && ({1'b0, palette_index} < DEPTH_LIM);

    // -------- configuration --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= clutd_pkg::MODE_4BIT;
            count_reg <= 9'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                clutd_pkg::REG_PIXEL_MODE:    mode_reg  <= cfg_wdata[1:0];
                clutd_pkg::REG_PALETTE_COUNT: count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // -------- sequencer --------
    always_comb
    begin
        case (mode_reg)
            clutd_pkg::MODE_4BIT: cnt_load = 2'd3;
            clutd_pkg::MODE_8BIT: cnt_load = 2'd1;
            default:              cnt_load = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_cnt_reg   <= 2'd0;
        end
        else if (dec_take)
        begin
            seq_valid_reg <= 1'b1;
            seq_cnt_reg   <= cnt_load;
        end
        else if (issue)
        begin
            if (seq_cnt_reg == 2'd0)
            begin
                seq_valid_reg <= 1'b0;
            end
            else
            begin
                seq_cnt_reg <= seq_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_take)
        begin
            seq_word_reg <= texture_word;
            seq_mode_reg <= mode_reg;
            seq_fin_reg  <= final_word;
        end
        else if (issue)
        begin
            // low pixel first: shift the next one down
            if (seq_mode_reg == clutd_pkg::MODE_4BIT)
            begin
                seq_word_reg <= {4'd0, seq_word_reg[15:4]};
            end
            else
            begin
                seq_word_reg <= {8'd0, seq_word_reg[15:8]};
            end
        end
    end

    // current index and range check against count and table size
    assign seq_idx  = (seq_mode_reg == clutd_pkg::MODE_4BIT)
                    ? {4'd0, seq_word_reg[3:0] & clutd_pkg::NIBBLE_MASK}
                    : seq_word_reg[7:0];
    assign in_table = ({1'b0, seq_idx} < count_reg) && ({1'b0, seq_idx} < DEPTH_LIM);
    assign ram_raddr = seq_idx[IDX_W-1:0];

    always_comb
    begin
        rd_ctl_next.direct = seq_word_reg;
        rd_ctl_next.last   = seq_fin_reg && (seq_cnt_reg == 2'd0);
        if ((seq_mode_reg == clutd_pkg::MODE_4BIT) || (seq_mode_reg == clutd_pkg::MODE_8BIT))
        begin
            rd_ctl_next.src = in_table ? clutd_pkg::SRC_TABLE : clutd_pkg::SRC_ZERO;
        end
        else
        begin
            rd_ctl_next.src = clutd_pkg::SRC_DIRECT;
        end
    end

    // -------- color table --------
    clutd_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (palette_index[IDX_W-1:0]),
        .wdata (palette_color),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // -------- read stage --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            rd_valid_reg <= 1'b1;
        end
        else if (rd_move)
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_ctl_reg <= rd_ctl_next;
        end
    end

    always_comb
    begin
        case (rd_ctl_reg.src)
            clutd_pkg::SRC_TABLE:  color = ram_rdata;
            clutd_pkg::SRC_DIRECT: color = rd_ctl_reg.direct;
            default:               color = 16'd0;
        endcase
    end

    // -------- output register --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            red_reg   <= clutd_pkg::expand5(color[4:0]);
            green_reg <= clutd_pkg::expand5(color[9:5]);
            blue_reg  <= clutd_pkg::expand5(color[14:10]);
            // bit 15 counts in the zero test
            alpha_reg <= (color == 16'd0) ? 8'd0 : clutd_pkg::ALPHA_OPAQUE;
            last_reg  <= rd_ctl_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign last_pixel = last_reg;

endmodule

>>> hw/rtl/clutd_checker.sv
// Port-level checks of the CLUT texture decoder, bound to its top level.
// Depends on clut_texture_decode_bgr555_macros.svh.
`include "clut_texture_decode_bgr555_macros.svh"

module clutd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha,
    input logic       last_pixel
);

    // stalled pixel holds
    `CLUTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({red, green, blue, alpha, last_pixel}), "stalled pixel changed")

    `CLUTD_ASSERT_NOW(a_alpha_code, out_valid, (alpha == 8'd0) || (alpha == 8'hFF), "alpha neither 0 nor 255")

    // transparent pixel comes from an all-zero color word
    `CLUTD_ASSERT_NOW(a_alpha_black, out_valid && (alpha == 8'd0), (red == 8'd0) && (green == 8'd0) && (blue == 8'd0), "transparent pixel with color")

    `CLUTD_ASSERT_NOW(a_expand, out_valid, (red[2:0] == red[7:5]) && (green[2:0] == green[7:5]) && (blue[2:0] == blue[7:5]), "channel not bit-replicated")

endmodule

bind clut_texture_decode_bgr555 clutd_checker u_clutd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .last_pixel (last_pixel)
);
